### sv/ect_pkg.sv
// ----------------------------------------------------------------------------
// ect_pkg: shared types and constants of the ear clipping triangulator
// Item formats, vertex store entry, cross product flags and sequencer states.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int COORD_BITS   = 16;
  localparam int FIELD_BITS   = 16;
  localparam int IDX_BITS     = 5;
  localparam int AW           = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int QDEPTH       = 2;
  localparam int QAW          = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW          = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] x;
    logic signed [FIELD_BITS-1:0] y;
    logic                         last;
  } vtx_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] ax;
    logic signed [FIELD_BITS-1:0] ay;
    logic signed [FIELD_BITS-1:0] bx;
    logic signed [FIELD_BITS-1:0] by;
    logic signed [FIELD_BITS-1:0] cx;
    logic signed [FIELD_BITS-1:0] cy;
    logic [IDX_BITS-1:0]          first_index;
    logic [IDX_BITS-1:0]          third_index;
    logic [1:0]                   corners;
    logic                         is_ear;
    logic                         stuck;
    logic                         done_res;
  } res_t;

  // Classified vertex on its way from the front to the back
  typedef struct packed {
    coord_t         x;
    coord_t         y;
    logic           last;
    logic           wr;
    logic [AW-1:0]  addr;
  } qitem_t;

  typedef struct packed {
    coord_t         x;
    coord_t         y;
    logic [AW-1:0]  orig;
  } entry_t;

  // Sign of one cross product
  typedef struct packed {
    logic pos;
    logic zero;
  } cross_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_stat_t;

  typedef enum logic [4:0] {
    B_IDLE, B_ROUND,
    C_A0, C_A1, C_A2, C_A3, C_A4, C_A5, C_A6, C_A7, C_A8,
    E_SEL, E_RD1, E_RD2, E_X3, E_X4, E_X5, E_X6, E_X7,
    EAR_OUT, M_RD, M_WR,
    F_0, F_1, F_2, F_3, F_4,
    STK_OUT
  } bstate_t;

  function automatic logic [IDX_BITS-1:0] to_idx(logic [AW-1:0] v);
    return IDX_BITS'(v);
  endfunction

  function automatic logic signed [FIELD_BITS-1:0] to_field(coord_t v);
    return FIELD_BITS'(v);
  endfunction

endpackage

### sv/ect_front.sv
// ----------------------------------------------------------------------------
// ect_front: vertex intake
// Accepts vertices, numbers them in load order and marks those beyond capacity.
// ----------------------------------------------------------------------------
module ect_front import ect_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   vtx_valid,
  output logic   vtx_stall,
  input  vtx_t   vtx,
  input  logic   q_full,
  output logic   q_push,
  output qitem_t q_item
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             keep;

  assign vtx_stall = q_full;
  assign q_push    = vtx_valid && !q_full;
  assign keep      = cnt < CNT_W'(MAX_VERTICES);

  always_comb begin
    q_item.x    = COORD_BITS'(vtx.x);
    q_item.y    = COORD_BITS'(vtx.y);
    q_item.last = vtx.last;
    q_item.wr   = keep;
    q_item.addr = cnt[AW-1:0];
  end

  always_comb begin
    cnt_next = cnt;
    if (q_push) begin
      if (vtx.last) cnt_next = '0;
      else if (keep) cnt_next = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else cnt <= cnt_next;
  end

endmodule

### sv/ect_queue.sv
// ----------------------------------------------------------------------------
// ect_queue: short FIFO between front and back
// Decouples vertex intake from the triangulation sequencer.
// ----------------------------------------------------------------------------
module ect_queue import ect_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  qitem_t din,
  input  logic   pop,
  output qitem_t dout,
  output logic   full,
  output logic   nempty
);

  qitem_t           slots [QDEPTH];
  logic [QAW-1:0]   wp;
  logic [QAW-1:0]   rp;
  logic [QCW-1:0]   cnt;

  assign full   = cnt == QCW'(QDEPTH);
  assign nempty = cnt != '0;
  assign dout   = slots[rp];

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= (wp == QAW'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == QAW'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + QCW'(push) - QCW'(pop);
    end
  end

endmodule

### sv/ect_cross.sv
// ----------------------------------------------------------------------------
// ect_cross: pipelined exact cross product sign
// Sign of (b - a) x (p - a); the two products are registered, then the flags.
// ----------------------------------------------------------------------------
module ect_cross import ect_pkg::*; (
  input  logic   clk,
  input  entry_t a,
  input  entry_t b,
  input  entry_t p,
  output cross_t flags
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 1;

  logic signed [DW-1:0] dbx, dby, dpx, dpy;
  logic signed [PW-1:0] p1, p2;
  logic signed [RW-1:0] diff;

  assign dbx  = DW'(b.x) - DW'(a.x);
  assign dby  = DW'(b.y) - DW'(a.y);
  assign dpx  = DW'(p.x) - DW'(a.x);
  assign dpy  = DW'(p.y) - DW'(a.y);
  assign diff = RW'(p1) - RW'(p2);

  always_ff @(posedge clk) begin
    p1         <= dbx * dpy;
    p2         <= dpx * dby;
    flags.pos  <= diff > 0;
    flags.zero <= diff == 0;
  end

endmodule

### sv/ect_back.sv
// ----------------------------------------------------------------------------
// ect_back: vertex store and ear clipping sequencer
// Stores vertices, searches ears with one cross product unit, emits results.
// ----------------------------------------------------------------------------
module ect_back import ect_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  qitem_t     q_item,
  input  logic       q_nempty,
  output logic       q_pop,
  output logic       res_valid,
  input  logic       res_stall,
  output res_t       res,
  output back_stat_t stat
);

  entry_t mem [MAX_VERTICES];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;

  bstate_t state, state_next;

  logic [CNT_W-1:0] n;
  logic [AW-1:0]    i, k, j;
  entry_t P0, PI, P1, P2, K, K1;
  cross_t s1, s2, sc, sd, se, cx;
  entry_t ca, cb, cp;

  logic [CNT_W-1:0] n_m1, i1c, i2c, k1c;
  logic [AW-1:0]    i0, i1, i2, k1;
  logic             last_i, last_k, skip, cone, meet, out_free, load;
  res_t             res_new;

  function automatic logic between(coord_t lo, coord_t hi, coord_t v);
    return (lo <= v && v <= hi) || (lo >= v && v >= hi);
  endfunction

  function automatic logic in_span(entry_t a, entry_t b, entry_t p);
    logic r;
    if (a.x != b.x) r = between(a.x, b.x, p.x);
    else r = between(a.y, b.y, p.y);
    return r;
  endfunction

  ect_cross u_cross (.clk(clk), .a(ca), .b(cb), .p(cp), .flags(cx));

  // Cyclic neighbours among live vertices
  always_comb begin
    n_m1   = n - 1'b1;
    i0     = (i == '0) ? n_m1[AW-1:0] : i - 1'b1;
    i1c    = CNT_W'(i) + 1'b1;
    i1     = (i1c == n) ? '0 : i1c[AW-1:0];
    i2c    = CNT_W'(i1) + 1'b1;
    i2     = (i2c == n) ? '0 : i2c[AW-1:0];
    k1c    = CNT_W'(k) + 1'b1;
    k1     = (k1c == n) ? '0 : k1c[AW-1:0];
    last_i = CNT_W'(i) == n_m1;
    last_k = CNT_W'(k) == n_m1;
    skip   = k == i || k1 == i || k == i2 || k1 == i2;
  end

  // Cone at the candidate; cx holds the sign of cross(i, i+2, i+1) here
  always_comb begin
    if (s1.pos || s1.zero) cone = s2.pos && !cx.pos && !cx.zero;
    else cone = !((cx.pos || cx.zero) && !s2.pos);
  end

  // Diagonal against edge k; cx holds the last of the four signs here
  always_comb begin
    meet = (!sc.zero && !sd.zero && !se.zero && !cx.zero
            && (sc.pos != sd.pos) && (se.pos != cx.pos))
        || (sc.zero && in_span(PI, P2, K))
        || (sd.zero && in_span(PI, P2, K1))
        || (se.zero && in_span(K, K1, PI))
        || (cx.zero && in_span(K, K1, P2));
  end

  assign out_free = !res_valid || !res_stall;

  always_comb begin
    ca = PI;
    cb = P2;
    cp = K;
    case (state)
      C_A4:    begin ca = P0; cb = PI; cp = P1; end
      C_A5:    cp = P0;
      C_A6:    cp = P1;
      E_X3:    cp = K1;
      E_X4:    begin ca = K; cb = K1; cp = PI; end
      E_X5:    begin ca = K; cb = K1; cp = P2; end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    we         = 1'b0;
    waddr      = q_item.addr;
    wdata.x    = q_item.x;
    wdata.y    = q_item.y;
    wdata.orig = q_item.addr;
    q_pop      = 1'b0;
    load       = 1'b0;
    res_new    = '0;
    case (state)
      B_IDLE: begin
        if (q_nempty) begin
          q_pop = 1'b1;
          we    = q_item.wr;
          if (q_item.last) state_next = B_ROUND;
        end
      end
      B_ROUND: state_next = (n <= CNT_W'(3)) ? F_0 : C_A0;
      C_A0: begin rd_addr = i0; state_next = C_A1; end
      C_A1: begin rd_addr = i;  state_next = C_A2; end
      C_A2: begin rd_addr = i1; state_next = C_A3; end
      C_A3: begin rd_addr = i2; state_next = C_A4; end
      C_A4: state_next = C_A5;
      C_A5: state_next = C_A6;
      C_A6: state_next = C_A7;
      C_A7: state_next = C_A8;
      C_A8: begin
        if (cone) state_next = E_SEL;
        else state_next = last_i ? STK_OUT : C_A0;
      end
      E_SEL: begin
        rd_addr = k;
        if (!skip) state_next = E_RD1;
        else if (last_k) state_next = EAR_OUT;
      end
      E_RD1: begin rd_addr = k1; state_next = E_RD2; end
      E_RD2: state_next = E_X3;
      E_X3:  state_next = E_X4;
      E_X4:  state_next = E_X5;
      E_X5:  state_next = E_X6;
      E_X6:  state_next = E_X7;
      E_X7: begin
        if (meet) state_next = last_i ? STK_OUT : C_A0;
        else state_next = last_k ? EAR_OUT : E_SEL;
      end
      EAR_OUT: begin
        res_new.ax          = to_field(PI.x);
        res_new.ay          = to_field(PI.y);
        res_new.bx          = to_field(P1.x);
        res_new.by          = to_field(P1.y);
        res_new.cx          = to_field(P2.x);
        res_new.cy          = to_field(P2.y);
        res_new.first_index = to_idx(PI.orig);
        res_new.third_index = to_idx(P2.orig);
        res_new.corners     = 2'd3;
        res_new.is_ear      = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = M_RD;
        end
      end
      M_RD: begin
        rd_addr = j + 1'b1;
        if (CNT_W'(j) == n_m1) state_next = B_ROUND;
        else state_next = M_WR;
      end
      M_WR: begin
        we         = 1'b1;
        waddr      = j;
        wdata      = rd_data;
        state_next = M_RD;
      end
      F_0: begin rd_addr = '0;     state_next = F_1; end
      F_1: begin rd_addr = AW'(1); state_next = F_2; end
      F_2: begin rd_addr = AW'(2); state_next = F_3; end
      F_3: state_next = F_4;
      F_4: begin
        if (n >= CNT_W'(1)) begin
          res_new.ax          = to_field(P0.x);
          res_new.ay          = to_field(P0.y);
          res_new.first_index = to_idx(P0.orig);
        end
        if (n >= CNT_W'(2)) begin
          res_new.bx = to_field(PI.x);
          res_new.by = to_field(PI.y);
        end
        if (n == CNT_W'(3)) begin
          res_new.cx          = to_field(P1.x);
          res_new.cy          = to_field(P1.y);
          res_new.third_index = to_idx(P1.orig);
        end
        res_new.corners  = n[1:0];
        res_new.done_res = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      STK_OUT: begin
        res_new.stuck    = 1'b1;
        res_new.done_res = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign stat.idle = state == B_IDLE;
  assign stat.pop  = q_pop;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      i <= '0;
      k <= '0;
      j <= '0;
    end else begin
      case (state)
        B_IDLE:  if (q_pop && q_item.wr) n <= CNT_W'(q_item.addr) + 1'b1;
        B_ROUND: i <= '0;
        C_A8: begin
          k <= '0;
          if (!cone) i <= i + 1'b1;
        end
        E_SEL:   if (skip) k <= k + 1'b1;
        E_X7: begin
          if (meet) begin
            i <= i + 1'b1;
            k <= '0;
          end else begin
            k <= k + 1'b1;
          end
        end
        EAR_OUT: j <= i1;
        M_RD:    if (CNT_W'(j) == n_m1) n <= n_m1;
        M_WR:    j <= j + 1'b1;
        F_4:     if (out_free) n <= '0;
        STK_OUT: if (out_free) n <= '0;
        default: ;
      endcase
    end
  end

  // Operand and sign capture
  always_ff @(posedge clk) begin
    case (state)
      C_A1:  P0 <= rd_data;
      C_A2:  PI <= rd_data;
      C_A3:  P1 <= rd_data;
      C_A4:  P2 <= rd_data;
      C_A6:  s1 <= cx;
      C_A7:  s2 <= cx;
      E_RD1: K  <= rd_data;
      E_RD2: K1 <= rd_data;
      E_X4:  sc <= cx;
      E_X5:  sd <= cx;
      E_X6:  se <= cx;
      F_1:   P0 <= rd_data;
      F_2:   PI <= rd_data;
      F_3:   P1 <= rd_data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (load) res_valid <= 1'b1;
    else if (!res_stall) res_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_new;
  end

endmodule

### sv/ear_clip_triangulator.sv
// Ear clipping triangulator.
// vtx channel: one polygon vertex per transfer (x, y, last). Vertices are
// numbered in load order; those beyond MAX_VERTICES are dropped, but a last
// flag on a dropped vertex still closes the polygon.
// res channel: one transfer per clipped ear (is_ear = 1), then a final
// transfer with done_res = 1 carrying the remaining corners, or carrying
// stuck = 1 when no ear is left to clip.
// Loading: one cycle per vertex while the sequencer is idle; a two-entry
// queue absorbs vertices while a polygon is being closed.
// Triangulation: each candidate steps through C_A0 to C_A8 and each edge tested
// through E_SEL to E_X7, a skipped edge only through E_SEL; a clipped ear shifts
// the store with one read (M_RD) and one write (M_WR) per moved entry. The pace
// is set by the single read port of the vertex store and the one shared,
// two stage cross product unit.
// A stalled result holds in the output register; the sequencer waits on it.
// Reset (synchronous, active high) empties the queue, drops any polygon in
// progress and clears the output valid. The vertex store is not cleared.
// ----------------------------------------------------------------------------
// ear_clip_triangulator: top level
// Front intake, queue and triangulation back end.
// ----------------------------------------------------------------------------
module ear_clip_triangulator import ect_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic vtx_valid,
  output logic vtx_stall,
  input  vtx_t vtx,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic       q_push, q_pop, q_full, q_nempty;
  qitem_t     q_in, q_out;
  back_stat_t stat;

  // Number and classify each vertex transfer
  ect_front u_front (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
    .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  // Hold classified vertices until the sequencer is idle
  ect_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .din(q_in), .pop(q_pop), .dout(q_out),
    .full(q_full), .nempty(q_nempty)
  );

  // Store vertices, clip ears, drive the result register
  ect_back u_back (
    .clk(clk), .rst(rst),
    .q_item(q_out), .q_nempty(q_nempty), .q_pop(q_pop),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .stat(stat)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full)) else $error("vertex queue overflow");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    stat.pop |-> stat.idle && q_nempty) else $error("queue popped while busy");

  a_ear_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_ear |-> res.corners == 2'd3 && !res.done_res && !res.stuck)
    else $error("malformed ear result");

  a_stuck_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.stuck |-> res.done_res && res.corners == 2'd0)
    else $error("malformed stuck result");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ear clipping triangulator
// Loads polygons through the vertex channel and checks every result against a
// behavioural ear clipper kept in step with the design, or a hand typed one.
// ----------------------------------------------------------------------------
module testbench;
  import ect_pkg::*;

  localparam int  RANDOM_ITEMS = 437;
  localparam longint CYCLE_LIMIT = 20_000_000;

  // Directed stimulus row: a vertex, and optionally the single result that
  // the polygon it closes must give, typed in by hand
  typedef struct {
    vtx_t v;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  logic vtx_stall;
  vtx_t vtx = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Shadow of the vertex store: coordinates, load positions and counts
  longint vx [MAX_VERTICES];
  longint vy [MAX_VERTICES];
  int     vorg [MAX_VERTICES];
  int     live_n = 0;
  int     load_n = 0;

  res_t   triangles_due[$];   // results still to arrive, oldest first
  res_t   fresh_tris[$];      // results of the polygon just closed
  int     errors = 0;
  int     items_sent = 0;
  longint cycles = 0;
  bit     calm = 0;           // no idling on either side while set
  int     stall_left = 0;

  // Half period inversion: 8 ns clock
  always #4 clk = ~clk;

  ear_clip_triangulator u_dut (
    .clk       (clk),
    .rst       (rst),
    .vtx_valid (vtx_valid),
    .vtx_stall (vtx_stall),
    .vtx       (vtx),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // ---------------------------------------------------------------- geometry
  // Exact orientation of p against the directed line a->b
  function automatic longint orient(int a, int b, int p);
    return (vx[b] - vx[a]) * (vy[p] - vy[a]) - (vx[p] - vx[a]) * (vy[b] - vy[a]);
  endfunction

  function automatic bit between(longint lo, longint hi, longint v);
    return (lo <= v && v <= hi) || (lo >= v && v >= hi);
  endfunction

  function automatic bit touches(int a, int b, int p);
    if (orient(a, b, p) != 0) return 0;
    if (vx[a] != vx[b]) return between(vx[a], vx[b], vx[p]);
    return between(vy[a], vy[b], vy[p]);
  endfunction

  function automatic bit segs_meet(int a, int b, int c, int d);
    bit proper;
    proper = 0;
    if (orient(a, b, c) != 0 && orient(a, b, d) != 0 &&
        orient(c, d, a) != 0 && orient(c, d, b) != 0) begin
      proper = ((orient(a, b, c) > 0) != (orient(a, b, d) > 0)) &&
               ((orient(c, d, a) > 0) != (orient(c, d, b) > 0));
    end
    return proper || touches(a, b, c) || touches(a, b, d) ||
           touches(c, d, a) || touches(c, d, b);
  endfunction

  // Diagonal i-j meets no edge that does not share an end with it
  function automatic bit diag_clear(int i, int j);
    int k1;
    for (int k = 0; k < live_n; k++) begin
      k1 = (k + 1) % live_n;
      if (k == i || k1 == i || k == j || k1 == j) continue;
      if (segs_meet(i, j, k, k1)) return 0;
    end
    return 1;
  endfunction

  // Diagonal a-b leaves a into the interior of the polygon
  function automatic bit in_cone(int a, int b);
    int a0, a1;
    a0 = (a + live_n - 1) % live_n;
    a1 = (a + 1) % live_n;
    if (orient(a0, a, a1) >= 0)
      return orient(a, b, a0) > 0 && orient(b, a, a1) > 0;
    return !(orient(a, b, a1) >= 0 && orient(b, a, a0) >= 0);
  endfunction

  function automatic void set_corner(ref res_t r, input int slot, input int v);
    case (slot)
      0: begin r.ax = vx[v][15:0]; r.ay = vy[v][15:0]; end
      1: begin r.bx = vx[v][15:0]; r.by = vy[v][15:0]; end
      default: begin r.cx = vx[v][15:0]; r.cy = vy[v][15:0]; end
    endcase
  endfunction

  // Clip ears until three corners remain or no ear is left
  function automatic void clip_polygon();
    res_t r;
    bit   found;
    int   i1, i2;
    forever begin
      r = '0;
      if (live_n <= 3) begin
        for (int c = 0; c < live_n; c++) set_corner(r, c, c);
        if (live_n > 0) r.first_index = vorg[0][4:0];
        if (live_n == 3) r.third_index = vorg[2][4:0];
        r.corners  = live_n[1:0];
        r.done_res = 1'b1;
        fresh_tris.insert(fresh_tris.size(), r);
        return;
      end
      found = 0;
      for (int i = 0; i < live_n && !found; i++) begin
        i1 = (i + 1) % live_n;
        i2 = (i + 2) % live_n;
        if (in_cone(i, i2) && diag_clear(i, i2)) begin
          set_corner(r, 0, i);
          set_corner(r, 1, i1);
          set_corner(r, 2, i2);
          r.first_index = vorg[i][4:0];
          r.third_index = vorg[i2][4:0];
          r.corners     = 2'd3;
          r.is_ear      = 1'b1;
          fresh_tris.insert(fresh_tris.size(), r);
          // Drop the tip and close the gap
          for (int k = i1; k < live_n - 1; k++) begin
            vx[k]   = vx[k + 1];
            vy[k]   = vy[k + 1];
            vorg[k] = vorg[k + 1];
          end
          live_n--;
          found = 1;
        end
      end
      if (!found) begin
        r.stuck    = 1'b1;
        r.done_res = 1'b1;
        fresh_tris.insert(fresh_tris.size(), r);
        return;
      end
    end
  endfunction

  // Take one accepted vertex; a last flag closes and triangulates the polygon
  function automatic void take_vertex(vtx_t v);
    if (load_n < MAX_VERTICES) begin
      vx[load_n]   = longint'(v.x);
      vy[load_n]   = longint'(v.y);
      vorg[load_n] = load_n;
      load_n++;
    end
    if (v.last) begin
      live_n = load_n;
      clip_polygon();
      live_n = 0;
      load_n = 0;
    end
  endfunction

  // ----------------------------------------------------------------- idling
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // Random back-pressure on the result channel
  always @(negedge clk) begin
    if (rst || calm) begin
      res_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_stall  <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = idle_len();
      res_stall  <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- driving
  // Offer one vertex after a random gap and hold it until the transfer
  task automatic send_vertex(vtx_t v, bit typed, res_t want);
    int g;
    g = idle_len();
    if (g > 0) begin
      @(negedge clk) vtx_valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    vtx_valid <= 1'b1;
    vtx       <= v;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
    take_vertex(v);
    if (typed && fresh_tris.size() > 0) begin
      fresh_tris.delete();
      triangles_due.insert(triangles_due.size(), want);
    end else begin
      while (fresh_tris.size() > 0)
        triangles_due.insert(triangles_due.size(), fresh_tris.pop_front());
    end
    items_sent++;
  endtask

  task automatic send_polygon(vtx_t q[$]);
    res_t none;
    none = '0;
    foreach (q[k]) send_vertex(q[k], 0, none);
  endtask

  // Star shaped polygon: points on a square outline taken in angular order,
  // each pulled towards the centre by a random factor, so always simple
  task automatic make_star(int n, ref vtx_t q[$]);
    int   ts[$];
    int   rad, cxc, cyc, side, off, dx, dy, f;
    vtx_t v;
    rad = ($urandom_range(0, 1) == 0) ? $urandom_range(8, 300) : $urandom_range(300, 32767);
    cxc = int'($urandom_range(0, 65535 - 2 * rad)) - 32768 + rad;
    cyc = int'($urandom_range(0, 65535 - 2 * rad)) - 32768 + rad;
    for (int k = 0; k < n; k++) ts.insert(ts.size(), $urandom_range(0, 8 * rad - 1));
    ts.sort();
    if ($urandom_range(0, 3) == 0) ts.reverse();
    q.delete();
    foreach (ts[k]) begin
      side = ts[k] / (2 * rad);
      off  = ts[k] % (2 * rad) - rad;
      case (side)
        0:       begin dx = rad;  dy = off;  end
        1:       begin dx = -off; dy = rad;  end
        2:       begin dx = -rad; dy = -off; end
        default: begin dx = off;  dy = -rad; end
      endcase
      f      = $urandom_range(4, 16);
      v.x    = 16'(cxc + dx * f / 16);
      v.y    = 16'(cyc + dy * f / 16);
      v.last = 1'b0;
      q.insert(q.size(), v);
    end
    q[q.size() - 1].last = 1'b1;
  endtask

  // --------------------------------------------------------------- checking
  function automatic void cmp(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && res_valid && !res_stall) begin
      if (triangles_due.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %p", $time, res);
        errors++;
      end else begin
        w = triangles_due.pop_front();
        cmp("ax", w.ax, res.ax);
        cmp("ay", w.ay, res.ay);
        cmp("bx", w.bx, res.bx);
        cmp("by", w.by, res.by);
        cmp("cx", w.cx, res.cx);
        cmp("cy", w.cy, res.cy);
        cmp("first_index", 16'(w.first_index), 16'(res.first_index));
        cmp("third_index", 16'(w.third_index), 16'(res.third_index));
        cmp("corners", 16'(w.corners), 16'(res.corners));
        cmp("is_ear", 16'(w.is_ear), 16'(res.is_ear));
        cmp("stuck", 16'(w.stuck), 16'(res.stuck));
        cmp("done_res", 16'(w.done_res), 16'(res.done_res));
      end
    end
  end

  function automatic dir_row_t row(int x, int y, bit last, bit typed = 0,
                                   res_t want = '0);
    dir_row_t r;
    r.v     = '{x: 16'(x), y: 16'(y), last: last};
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // --------------------------------------------------------------- sequence
  initial begin : main
    dir_row_t dir_tab[$];
    vtx_t     poly[$];
    vtx_t     v;
    res_t     t;
    int       kind, n;
    bit       first_pass;

    // Single vertex at the corner of the coordinate range
    t = '0; t.ax = 16'h8000; t.ay = 16'h7fff; t.corners = 2'd1; t.done_res = 1'b1;
    dir_tab.insert(dir_tab.size(), row(-32768, 32767, 1, 1, t));
    // Two vertices: a line with the other two extremes
    t = '0; t.ax = 16'h7fff; t.ay = 16'h8000; t.corners = 2'd2; t.done_res = 1'b1;
    dir_tab.insert(dir_tab.size(), row(32767, -32768, 0));
    dir_tab.insert(dir_tab.size(), row(0, 0, 1, 1, t));
    // Plain triangle: remainder only, no ear
    t = '0; t.bx = 16'd10; t.cy = 16'd10; t.third_index = 5'd2;
    t.corners = 2'd3; t.done_res = 1'b1;
    dir_tab.insert(dir_tab.size(), row(0, 0, 0));
    dir_tab.insert(dir_tab.size(), row(10, 0, 0));
    dir_tab.insert(dir_tab.size(), row(0, 10, 1, 1, t));
    // Four collinear points: no ear anywhere
    t = '0; t.stuck = 1'b1; t.done_res = 1'b1;
    dir_tab.insert(dir_tab.size(), row(0, 0, 0));
    dir_tab.insert(dir_tab.size(), row(1, 0, 0));
    dir_tab.insert(dir_tab.size(), row(2, 0, 0));
    dir_tab.insert(dir_tab.size(), row(3, 0, 1, 1, t));
    // Full range square
    dir_tab.insert(dir_tab.size(), row(-32768, -32768, 0));
    dir_tab.insert(dir_tab.size(), row(32767, -32768, 0));
    dir_tab.insert(dir_tab.size(), row(32767, 32767, 0));
    dir_tab.insert(dir_tab.size(), row(-32768, 32767, 1));
    // Concave pentagon
    dir_tab.insert(dir_tab.size(), row(0, 0, 0));
    dir_tab.insert(dir_tab.size(), row(20, 0, 0));
    dir_tab.insert(dir_tab.size(), row(10, 5, 0));
    dir_tab.insert(dir_tab.size(), row(20, 20, 0));
    dir_tab.insert(dir_tab.size(), row(0, 20, 1));
    // Repeated vertex
    dir_tab.insert(dir_tab.size(), row(5, 5, 0));
    dir_tab.insert(dir_tab.size(), row(5, 5, 0));
    dir_tab.insert(dir_tab.size(), row(9, 1, 0));
    dir_tab.insert(dir_tab.size(), row(1, 9, 1));

    // Hold reset, then release it at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_tab[k]) send_vertex(dir_tab[k].v, dir_tab[k].typed, dir_tab[k].want);

    first_pass = 1;
    while (items_sent < 23 + RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (first_pass || kind < 2) begin
        // Over capacity: vertices past the store size are dropped
        make_star($urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 4), poly);
      end else if (kind < 75) begin
        n = $urandom_range(0, 99);
        n = (n < 80) ? $urandom_range(3, 8) : (n < 97) ? $urandom_range(9, 16)
                                                      : $urandom_range(17, 32);
        make_star(n, poly);
      end else if (kind < 85) begin
        // Well-formed outline with two vertices swapped: often self crossing
        make_star($urandom_range(5, 9), poly);
        v = poly[1];
        poly[1] = poly[3];
        poly[3] = v;
        poly[1].last = 1'b0;
        poly[3].last = 1'b0;
        poly[poly.size() - 1].last = 1'b1;
      end else begin
        // Noise: free coordinates, or a tiny grid full of repeats and lines
        n = $urandom_range(3, 7);
        poly.delete();
        for (int k = 0; k < n; k++) begin
          if (kind < 93) begin
            v.x = 16'($urandom);
            v.y = 16'($urandom);
          end else begin
            v.x = 16'($urandom_range(0, 3));
            v.y = 16'($urandom_range(0, 3));
          end
          v.last = (k == n - 1);
          poly.insert(poly.size(), v);
        end
      end
      first_pass = 0;
      send_polygon(poly);
    end
    @(negedge clk) vtx_valid <= 1'b0;
    calm = 0;

    while (triangles_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
